/* hdl/tfd_pkg.sv */
// Package for the tactile frame decoder: frame layout constants, status codes
// and the structs passed between the frame front end and the record emitter.
// No dependencies.
package tfd_pkg;

    localparam int FRAME_BYTES   = 96;
    localparam int NUM_CHANNELS  = 26;
    localparam int STORE_BASE    = 4;
    localparam int STORE_DEPTH   = 92;
    localparam int SUM_LEN       = 94;
    localparam int STORE_AW      = $clog2(STORE_DEPTH);

    localparam logic [7:0] HDR_A   = 8'h55;
    localparam logic [7:0] HDR_B   = 8'hAA;
    localparam logic [7:0] HDR_CMD = 8'h85;

    // Byte offsets inside the frame.
    localparam int OFS_SEQUENCE = 4;
    localparam int OFS_COUNT    = 5;
    localparam int OFS_CHANNELS = 6;
    localparam int OFS_TAIL     = 84;
    localparam int TAIL_BYTES   = 10;
    localparam int OFS_SUM_LO   = 94;

    localparam int TAIL_AW = $clog2(TAIL_BYTES);

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LENGTH = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_BAD_COUNT  = 3'd3,
        ST_BAD_SUM    = 3'd4
    } t_status;

    typedef logic [STORE_AW-1:0] t_store_addr;

    typedef struct packed {
        logic        en;
        t_store_addr addr;
        logic [7:0]  data;
    } t_store_wr;

    typedef struct packed {
        logic [7:0]  sequence_res;
        logic [15:0] press_force;
        logic [15:0] shear_force;
        logic [15:0] shear_angle;
        logic [23:0] proximity;
        logic [7:0]  unit_status;
    } t_frame_info;

    typedef struct packed {
        logic        valid;
        t_status     status;
        t_frame_info info;
    } t_emit_req;

endpackage

/* hdl/tfd_if.sv */
// Channel interfaces of the tactile frame decoder: the received byte stream
// and the decoded record stream. No dependencies.
interface tfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_buffer;

    modport source (output valid, output rx_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface tfd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [4:0]         channel_index;
    logic [23:0]        raw_value;
    logic [7:0]         sequence_res;
    logic signed [15:0] press_force;
    logic signed [15:0] shear_force;
    logic [15:0]        shear_angle;
    logic [23:0]        proximity;
    logic [7:0]         unit_status;
    logic               last;

    modport source (
        output valid, output status, output channel_index, output raw_value,
        output sequence_res, output press_force, output shear_force,
        output shear_angle, output proximity, output unit_status, output last,
        input ready
    );
    modport sink (
        input valid, input status, input channel_index, input raw_value,
        input sequence_res, input press_force, input shear_force,
        input shear_angle, input proximity, input unit_status, input last,
        output ready
    );
endinterface

/* hdl/tfd_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module tfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 92
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tfd_front.sv */
// Frame front end: header hunt, frame collection into the store, checksum and
// the decision that starts the record emitter. Depends on tfd_pkg.
module tfd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_node_address,
    input  logic               i_accept,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_end_of_buffer,
    output tfd_pkg::t_store_wr o_wr,
    output tfd_pkg::t_emit_req o_req
);
    import tfd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_COLLECT,
        PH_DONE
    } t_phase;

    localparam logic [15:0] SUM_SEED = 16'(HDR_A) + 16'(HDR_B) + 16'(HDR_CMD);

    t_phase      r_phase, n_phase;
    logic [23:0] r_window, n_window;
    logic [6:0]  r_total, n_total;
    logic [6:0]  r_fill, n_fill;
    logic [15:0] r_sum, n_sum;
    logic        r_req_valid, n_req_valid;
    t_status     r_req_status, n_req_status;

    logic [7:0]  r_seq;
    logic [7:0]  r_count;
    logic [7:0]  r_tail [TAIL_BYTES];
    logic [7:0]  r_sum_lo;

    logic        decide_now;
    logic        header_hit;
    logic        collecting;

    assign collecting = i_accept && (r_phase == PH_COLLECT);
    assign header_hit = (r_window[23:16] == HDR_A) && (r_window[15:8] == HDR_B) &&
                        (r_window[7:0] == i_node_address) && (i_rx_byte == HDR_CMD);

    always_comb begin
        n_phase      = r_phase;
        n_window     = r_window;
        n_total      = r_total;
        n_fill       = r_fill;
        n_sum        = r_sum;
        n_req_valid  = 1'b0;
        n_req_status = r_req_status;
        decide_now   = 1'b0;

        if (i_accept) begin
            if (32'(r_total) < FRAME_BYTES) begin
                n_total = r_total + 7'd1;
            end

            case (r_phase)
                PH_HUNT: begin
                    if (header_hit) begin
                        n_phase = PH_COLLECT;
                        n_fill  = 7'(STORE_BASE);
                        n_sum   = SUM_SEED + {8'd0, i_node_address};
                    end
                    n_window = {r_window[15:0], i_rx_byte};
                end
                PH_COLLECT: begin
                    if (32'(r_fill) < SUM_LEN) begin
                        n_sum = r_sum + {8'd0, i_rx_byte};
                    end
                    n_fill = r_fill + 7'd1;
                    if (32'(r_fill) == FRAME_BYTES - 1) begin
                        // Last byte of the frame: the checksum word is now complete.
                        decide_now  = 1'b1;
                        n_phase     = PH_DONE;
                        n_req_valid = 1'b1;
                        if (32'(r_count) != NUM_CHANNELS) begin
                            n_req_status = ST_BAD_COUNT;
                        end else if ({i_rx_byte, r_sum_lo} != r_sum) begin
                            n_req_status = ST_BAD_SUM;
                        end else begin
                            n_req_status = ST_OK;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (i_end_of_buffer) begin
                if (!decide_now) begin
                    if (32'(n_total) < FRAME_BYTES) begin
                        n_req_valid  = 1'b1;
                        n_req_status = ST_BAD_LENGTH;
                    end else if (r_phase != PH_DONE) begin
                        n_req_valid  = 1'b1;
                        n_req_status = ST_BAD_HEADER;
                    end
                end
                n_phase  = PH_HUNT;
                n_window = '0;
                n_total  = '0;
                n_fill   = '0;
                n_sum    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_window     <= '0;
            r_total      <= '0;
            r_fill       <= '0;
            r_sum        <= '0;
            r_req_valid  <= 1'b0;
            r_req_status <= ST_OK;
        end else begin
            r_phase      <= n_phase;
            r_window     <= n_window;
            r_total      <= n_total;
            r_fill       <= n_fill;
            r_sum        <= n_sum;
            r_req_valid  <= n_req_valid;
            r_req_status <= n_req_status;
        end

        // The fixed fields are kept beside the store so the emitter only
        // has to fetch channel bytes.
        if (collecting) begin
            if (32'(r_fill) == OFS_SEQUENCE) begin
                r_seq <= i_rx_byte;
            end
            if (32'(r_fill) == OFS_COUNT) begin
                r_count <= i_rx_byte;
            end
            if (32'(r_fill) >= OFS_TAIL && 32'(r_fill) < OFS_TAIL + TAIL_BYTES) begin
                r_tail[TAIL_AW'(r_fill - 7'(OFS_TAIL))] <= i_rx_byte;
            end
            if (32'(r_fill) == OFS_SUM_LO) begin
                r_sum_lo <= i_rx_byte;
            end
        end
    end

    assign o_wr.en   = collecting;
    assign o_wr.addr = STORE_AW'(r_fill - 7'(STORE_BASE));
    assign o_wr.data = i_rx_byte;

    assign o_req.valid             = r_req_valid;
    assign o_req.status            = r_req_status;
    assign o_req.info.sequence_res = r_seq;
    assign o_req.info.press_force  = {r_tail[1], r_tail[0]};
    assign o_req.info.shear_force  = {r_tail[3], r_tail[2]};
    assign o_req.info.shear_angle  = {r_tail[5], r_tail[4]};
    assign o_req.info.proximity    = {r_tail[8], r_tail[7], r_tail[6]};
    assign o_req.info.unit_status  = r_tail[9];

endmodule

/* hdl/tfd_emit.sv */
// Record emitter: reads channel bytes back from the frame store and presents
// one record per channel, or a single error record. Depends on tfd_pkg and
// tfd_out_if.
module tfd_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tfd_pkg::t_emit_req    i_req,
    input  logic [7:0]            i_rd_data,
    output tfd_pkg::t_store_addr  o_rd_addr,
    output logic                  o_idle,
    tfd_out_if.source             o_rec
);
    import tfd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHOW
    } t_state;

    localparam t_store_addr CH_ADDR0 = STORE_AW'(OFS_CHANNELS - STORE_BASE);

    t_state      r_state;
    t_store_addr r_addr;
    logic [1:0]  r_sub;
    logic [7:0]  r_b0, r_b1;
    logic [4:0]  r_chan;

    t_status     r_status;
    logic [4:0]  r_channel_index;
    logic [23:0] r_raw_value;
    t_frame_info r_info;
    logic        r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sub   <= '0;
            r_chan  <= '0;
            r_addr  <= CH_ADDR0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_chan          <= '0;
                        r_addr          <= CH_ADDR0;
                        r_sub           <= '0;
                        r_status        <= i_req.status;
                        r_channel_index <= '0;
                        r_raw_value     <= '0;
                        if (i_req.status != ST_OK) begin
                            // Error records carry only the status and the last flag.
                            r_info  <= '0;
                            r_last  <= 1'b1;
                            r_state <= S_SHOW;
                        end else begin
                            r_info  <= i_req.info;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    // One read issued per cycle; data returns in the next cycle.
                    r_sub <= r_sub + 2'd1;
                    if (r_sub != 2'd3) begin
                        r_addr <= r_addr + STORE_AW'(1);
                    end
                    case (r_sub)
                        2'd1: r_b0 <= i_rd_data;
                        2'd2: r_b1 <= i_rd_data;
                        2'd3: begin
                            r_raw_value     <= {i_rd_data, r_b1, r_b0};
                            r_channel_index <= r_chan;
                            r_last          <= (32'(r_chan) == NUM_CHANNELS - 1);
                            r_state         <= S_SHOW;
                        end
                        default: begin
                        end
                    endcase
                end
                S_SHOW: begin
                    if (o_rec.ready) begin
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_chan  <= r_chan + 5'd1;
                            r_sub   <= '0;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rd_addr = r_addr;
    assign o_idle    = (r_state == S_IDLE);

    assign o_rec.valid         = (r_state == S_SHOW);
    assign o_rec.status        = r_status;
    assign o_rec.channel_index = r_channel_index;
    assign o_rec.raw_value     = r_raw_value;
    assign o_rec.sequence_res  = r_info.sequence_res;
    assign o_rec.press_force   = r_info.press_force;
    assign o_rec.shear_force   = r_info.shear_force;
    assign o_rec.shear_angle   = r_info.shear_angle;
    assign o_rec.proximity     = r_info.proximity;
    assign o_rec.unit_status   = r_info.unit_status;
    assign o_rec.last          = r_last;

endmodule

/* hdl/tactile_frame_decoder.sv */
// Top level of the tactile frame decoder: node address register, front end,
// frame store and record emitter. Depends on tfd_pkg, tfd_if, tfd_ram,
// tfd_front and tfd_emit.
//
//   Channel   Direction  Handshake      Carries
//   i_rx      in         valid/ready    rx_byte, end_of_buffer
//   o_rec     out        valid/ready    status, channel_index, raw_value and frame fields
//   i_cfg_*   in         write enable   node_address
//
// Cycles: one byte transaction per cycle while no record is pending. A good frame
// stalls the byte channel for the decision, then per record for the store reads
// and the output. An error record stalls it for the decision and its output.
// Reset is synchronous and active low and clears all control state; the store is
// read only after a full frame was written.
// A stall on the record channel holds the record and the byte channel with it.
module tactile_frame_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    tfd_in_if.sink     i_rx,
    tfd_out_if.source  o_rec
);
    import tfd_pkg::*;

    logic [7:0]  r_node_address;
    t_store_wr   store_wr;
    t_emit_req   emit_req;
    t_store_addr rd_addr;
    logic [7:0]  rd_data;
    logic        emit_idle;
    logic        rx_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_address <= '0;
        end else if (i_cfg_we) begin
            r_node_address <= i_cfg_wdata;
        end
    end

    // Bytes are taken only while the emitter is idle and no decision is on
    // its way to it, so the store is never written while it is read back.
    assign i_rx.ready = emit_idle && !emit_req.valid;
    assign rx_accept  = i_rx.valid && i_rx.ready;

    tfd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_node_address  (r_node_address),
        .i_accept        (rx_accept),
        .i_rx_byte       (i_rx.rx_byte),
        .i_end_of_buffer (i_rx.end_of_buffer),
        .o_wr            (store_wr),
        .o_req           (emit_req)
    );

    tfd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_wr.en),
        .i_waddr (store_wr.addr),
        .i_wdata (store_wr.data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    tfd_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (emit_req),
        .i_rd_data (rd_data),
        .o_rd_addr (rd_addr),
        .o_idle    (emit_idle),
        .o_rec     (o_rec)
    );

endmodule
